// ----- hw/rtl/bhpq_pkg.sv -----
// Shared types, codes and microcode program for the binary heap priority queue.
package bhpq_pkg;

    localparam int VAL_W  = 32;
    localparam int STAT_W = 2;

    // Request codes
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_REMOVE = 1'b1;

    // Order codes
    localparam logic ORDER_MIN = 1'b0;
    localparam logic ORDER_MAX = 1'b1;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

    typedef logic [3:0] t_upc;
    typedef logic [3:0] t_act;
    typedef logic [3:0] t_cond;

    // Step addresses of the control program
    localparam t_upc S_IDLE    = 4'd0;
    localparam t_upc S_DISP    = 4'd1;
    localparam t_upc S_INS     = 4'd2;
    localparam t_upc S_UP_RD   = 4'd3;
    localparam t_upc S_UP_CMP  = 4'd4;
    localparam t_upc S_DN_INIT = 4'd5;
    localparam t_upc S_DN_LOAD = 4'd6;
    localparam t_upc S_DN_RD   = 4'd7;
    localparam t_upc S_DN_CMP  = 4'd8;
    localparam t_upc S_PLACE   = 4'd9;
    localparam t_upc S_FIN     = 4'd10;

    // Datapath actions
    localparam t_act A_NONE      = 4'd0;
    localparam t_act A_ACCEPT    = 4'd1;
    localparam t_act A_INS_INIT  = 4'd2;
    localparam t_act A_RD_PARENT = 4'd3;
    localparam t_act A_UP_MOVE   = 4'd4;
    localparam t_act A_DN_INIT   = 4'd5;
    localparam t_act A_LOAD_CUR  = 4'd6;
    localparam t_act A_RD_KIDS   = 4'd7;
    localparam t_act A_DN_MOVE   = 4'd8;
    localparam t_act A_PLACE     = 4'd9;
    localparam t_act A_EMIT      = 4'd10;

    // Branch conditions
    localparam t_cond C_ALWAYS   = 4'd0;
    localparam t_cond C_IN_ACC   = 4'd1;
    localparam t_cond C_REMOVE   = 4'd2;
    localparam t_cond C_FULL     = 4'd3;
    localparam t_cond C_EMPTY    = 4'd4;
    localparam t_cond C_AT_ROOT  = 4'd5;
    localparam t_cond C_UP_STOP  = 4'd6;
    localparam t_cond C_NO_KID   = 4'd7;
    localparam t_cond C_DN_STOP  = 4'd8;
    localparam t_cond C_OUT_FREE = 4'd9;

    typedef struct packed {
        t_act  act;
        t_cond cond;
        t_upc  jt;
        t_upc  jf;
    } t_uword;

    typedef struct packed {
        logic in_acc;
        logic remove;
        logic full;
        logic empty;
        logic at_root;
        logic up_stop;
        logic no_kid;
        logic dn_stop;
        logic out_free;
    } t_flags;

    function automatic t_uword ucode(input t_upc upc);
        t_uword w;
        case (upc)
            S_IDLE:    w = '{A_ACCEPT,    C_IN_ACC,   S_DISP,    S_IDLE};
            S_DISP:    w = '{A_NONE,      C_REMOVE,   S_DN_INIT, S_INS};
            S_INS:     w = '{A_INS_INIT,  C_FULL,     S_FIN,     S_UP_RD};
            S_UP_RD:   w = '{A_RD_PARENT, C_AT_ROOT,  S_PLACE,   S_UP_CMP};
            S_UP_CMP:  w = '{A_UP_MOVE,   C_UP_STOP,  S_PLACE,   S_UP_RD};
            S_DN_INIT: w = '{A_DN_INIT,   C_EMPTY,    S_FIN,     S_DN_LOAD};
            S_DN_LOAD: w = '{A_LOAD_CUR,  C_ALWAYS,   S_DN_RD,   S_DN_RD};
            S_DN_RD:   w = '{A_RD_KIDS,   C_NO_KID,   S_PLACE,   S_DN_CMP};
            S_DN_CMP:  w = '{A_DN_MOVE,   C_DN_STOP,  S_PLACE,   S_DN_RD};
            S_PLACE:   w = '{A_PLACE,     C_ALWAYS,   S_FIN,     S_FIN};
            S_FIN:     w = '{A_EMIT,      C_OUT_FREE, S_IDLE,    S_FIN};
            default:   w = '{A_NONE,      C_ALWAYS,   S_IDLE,    S_IDLE};
        endcase
        return w;
    endfunction

    // True when a ranks strictly above b under the selected order
    function automatic logic ranks_above(
        input logic signed [VAL_W-1:0] a,
        input logic signed [VAL_W-1:0] b,
        input logic                    order
    );
        return (order == ORDER_MAX) ? (a > b) : (a < b);
    endfunction

endpackage

// ----- hw/rtl/binary_heap_priority_queue.sv -----
// Top level of the binary heap priority queue (min-first or max-first).
// Insert climbs from a new last slot toward the root; remove moves the last entry to the root
// and sinks it toward a leaf. An insert on a full heap is dropped, a remove on an empty one ignored.
// Throughput: one transaction at a time; the next is accepted in the cycle after the result loads,
// later while the result stalls. Reset (synchronous, active low) empties, selects min-first.
module binary_heap_priority_queue
    import bhpq_pkg::*;
#(
    parameter  int CAPACITY = 64,
    localparam int AW       = $clog2(CAPACITY),
    localparam int CW       = $clog2(CAPACITY + 1)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // configuration write channel
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic                    i_cfg_heap_order,
    // request channel
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic                    i_req_type,
    input  logic signed [VAL_W-1:0] i_value,
    // result channel
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic signed [VAL_W-1:0] o_top_value,
    output logic [CW-1:0]           o_entry_count,
    output logic                    o_is_empty,
    output logic [STAT_W-1:0]       o_status
);

    // Heap store: one write port, two registered read ports.
    logic signed [VAL_W-1:0] r_mem [CAPACITY];
    logic signed [VAL_W-1:0] r_rd0;
    logic signed [VAL_W-1:0] r_rd1;

    // Sift state. The moving entry lives in r_cur and is written once it settles,
    // so every level moves one neighbor instead of swapping two entries.
    logic                    r_order;
    logic                    r_req,    n_req;
    logic signed [VAL_W-1:0] r_cur,    n_cur;
    logic [AW-1:0]           r_pos,    n_pos;
    logic [CW-1:0]           r_count,  n_count;
    logic [STAT_W-1:0]       r_status, n_status;
    logic signed [VAL_W-1:0] r_top;   // mirror of the root entry

    // Output register
    logic                    r_out_valid;
    logic signed [VAL_W-1:0] r_out_top;
    logic [CW-1:0]           r_out_count;
    logic [STAT_W-1:0]       r_out_status;

    t_uword uw;
    t_flags flags;

    logic                    in_acc;
    logic                    out_free;
    logic                    mem_we;
    logic [AW-1:0]           wr_addr;
    logic signed [VAL_W-1:0] wr_data;
    logic [AW-1:0]           rd_addr0;
    logic [AW-1:0]           rd_addr1;
    logic [AW-1:0]           parent;
    logic [AW:0]             kid_l;
    logic [AW:0]             kid_r;
    logic [AW:0]             cnt_x;
    logic [CW-1:0]           cnt_dec;
    logic                    has_right;
    logic                    pick_right;
    logic signed [VAL_W-1:0] best_val;
    logic [AW-1:0]           best_idx;
    logic                    up_stop;
    logic                    dn_stop;

    bhpq_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (flags),
        .o_uword (uw)
    );

    // Take requests and configuration only in the idle step.
    assign o_in_stall  = (uw.act != A_ACCEPT);
    assign o_cfg_ready = (uw.act == A_ACCEPT);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;

    // Tree addressing
    assign parent  = (r_pos - AW'(1)) >> 1;
    assign kid_l   = {r_pos, 1'b1};
    assign kid_r   = kid_l + (AW+1)'(1);
    assign cnt_x   = (AW+1)'(r_count);
    assign cnt_dec = r_count - CW'(1);

    // Sift-up: stop once the moving entry does not outrank its parent.
    assign up_stop = !ranks_above(r_cur, r_rd0, r_order);

    // Sift-down: left child wins ties; stop once the best child does not outrank.
    assign has_right  = (kid_r < cnt_x);
    assign pick_right = has_right && ranks_above(r_rd1, r_rd0, r_order);
    assign best_val   = pick_right ? r_rd1 : r_rd0;
    assign best_idx   = pick_right ? kid_r[AW-1:0] : kid_l[AW-1:0];
    assign dn_stop    = !ranks_above(best_val, r_cur, r_order);

    always_comb begin
        flags.in_acc   = in_acc;
        flags.remove   = (r_req == REQ_REMOVE);
        flags.full     = (r_count == CW'(CAPACITY));
        flags.empty    = (r_count == '0);
        flags.at_root  = (r_pos == '0);
        flags.up_stop  = up_stop;
        flags.no_kid   = (kid_l >= cnt_x);
        flags.dn_stop  = dn_stop;
        flags.out_free = out_free;
    end

    // Datapath control decoded from the current control word.
    always_comb begin
        n_req    = r_req;
        n_cur    = r_cur;
        n_pos    = r_pos;
        n_count  = r_count;
        n_status = r_status;
        mem_we   = 1'b0;
        wr_addr  = r_pos;
        wr_data  = r_cur;
        rd_addr0 = parent;
        rd_addr1 = kid_r[AW-1:0];
        case (uw.act)
            A_ACCEPT: begin
                if (in_acc) begin
                    n_req = i_req_type;
                    n_cur = i_value;
                end
            end
            A_INS_INIT: begin
                // Drop the insert when full; otherwise open a slot at the end.
                if (flags.full) begin
                    n_status = ST_FULL;
                end else begin
                    n_status = ST_OK;
                    n_pos    = r_count[AW-1:0];
                    n_count  = r_count + CW'(1);
                end
            end
            A_UP_MOVE: begin
                // Pull the parent down into the hole and climb.
                if (!up_stop) begin
                    mem_we  = 1'b1;
                    wr_data = r_rd0;
                    n_pos   = parent;
                end
            end
            A_DN_INIT: begin
                // Ignore the remove when empty; otherwise fetch the last entry.
                rd_addr0 = cnt_dec[AW-1:0];
                if (flags.empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_status = ST_OK;
                    n_count  = cnt_dec;
                    n_pos    = '0;
                end
            end
            A_LOAD_CUR: begin
                n_cur = r_rd0;
            end
            A_RD_KIDS: begin
                rd_addr0 = kid_l[AW-1:0];
            end
            A_DN_MOVE: begin
                // Lift the better child into the hole and descend.
                if (!dn_stop) begin
                    mem_we  = 1'b1;
                    wr_data = best_val;
                    n_pos   = best_idx;
                end
            end
            A_PLACE: begin
                mem_we = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Store: write, then registered reads.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd0 <= r_mem[rd_addr0];
        r_rd1 <= r_mem[rd_addr1];
    end

    // Track the root so the result never needs a store read.
    always_ff @(posedge i_clk) begin
        if (mem_we && (wr_addr == '0)) begin
            r_top <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req    <= n_req;
        r_cur    <= n_cur;
        r_pos    <= n_pos;
        r_status <= n_status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_order <= ORDER_MIN;
        end else begin
            r_count <= n_count;
            if (i_cfg_valid && o_cfg_ready) begin
                r_order <= i_cfg_heap_order;
            end
        end
    end

    // Result register: load in the final step once the previous result has left.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((uw.act == A_EMIT) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((uw.act == A_EMIT) && out_free) begin
            r_out_top    <= (r_count == '0) ? '0 : r_top;
            r_out_count  <= r_count;
            r_out_status <= r_status;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_top_value   = r_out_top;
    assign o_entry_count = r_out_count;
    assign o_is_empty    = (r_out_count == '0);
    assign o_status      = r_out_status;

endmodule

// ----- hw/rtl/bhpq_useq.sv -----
// Microcode sequencer: step counter, control ROM and conditional branch select.
module bhpq_useq
    import bhpq_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_flags i_flags,
    output t_uword o_uword
);

    t_upc   r_upc;
    t_upc   n_upc;
    t_uword uw;
    logic   take;

    assign uw      = ucode(r_upc);
    assign o_uword = uw;

    always_comb begin
        case (uw.cond)
            C_ALWAYS:   take = 1'b1;
            C_IN_ACC:   take = i_flags.in_acc;
            C_REMOVE:   take = i_flags.remove;
            C_FULL:     take = i_flags.full;
            C_EMPTY:    take = i_flags.empty;
            C_AT_ROOT:  take = i_flags.at_root;
            C_UP_STOP:  take = i_flags.up_stop;
            C_NO_KID:   take = i_flags.no_kid;
            C_DN_STOP:  take = i_flags.dn_stop;
            C_OUT_FREE: take = i_flags.out_free;
            default:    take = 1'b1;
        endcase
        n_upc = take ? uw.jt : uw.jf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= S_IDLE;
        end else begin
            r_upc <= n_upc;
        end
    end

endmodule

// ----- hw/rtl/bhpq_checker.sv -----
// Port-level checker for the binary heap priority queue, bound to the top level.
module bhpq_checker
    import bhpq_pkg::*;
#(
    parameter  int CAPACITY = 64,
    localparam int CW       = $clog2(CAPACITY + 1)
) (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    o_out_valid,
    input logic                    i_out_stall,
    input logic signed [VAL_W-1:0] o_top_value,
    input logic [CW-1:0]           o_entry_count,
    input logic                    o_is_empty,
    input logic [STAT_W-1:0]       o_status
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_is_empty == (o_entry_count == '0)))
        else $error("empty flag disagrees with count");

    a_empty_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_is_empty |-> (o_top_value == '0))
        else $error("empty heap shows nonzero top");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_FULL) |-> (o_entry_count == CW'(CAPACITY)))
        else $error("full status without full count");

    a_empty_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_EMPTY) |-> o_is_empty)
        else $error("empty status on a nonempty heap");

endmodule

bind binary_heap_priority_queue bhpq_checker #(.CAPACITY(CAPACITY)) u_bhpq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_top_value   (o_top_value),
    .o_entry_count (o_entry_count),
    .o_is_empty    (o_is_empty),
    .o_status      (o_status)
);

// ----- sim/binary_heap_priority_queue_tb.sv -----
// Testbench for binary_heap_priority_queue: directed and random heap traffic checked against a predictor.
module binary_heap_priority_queue_tb;
    import bhpq_pkg::*;

    localparam int CAPACITY      = 64;
    localparam int CW            = $clog2(CAPACITY + 1);
    localparam int TOTAL_ITEMS   = 1250;
    localparam int HOLD_CYCLES   = 300;
    localparam int IDLE_LIMIT    = 4000;
    localparam int SETTLE_CYCLES = 40;
    localparam int MAX_SHOWN     = 10;

    typedef struct packed {
        logic signed [VAL_W-1:0] top_value;
        logic [CW-1:0]           entry_count;
        logic                    is_empty;
        logic [STAT_W-1:0]       status;
    } t_heap_result;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_cfg_valid;
    logic                    o_cfg_ready;
    logic                    i_cfg_heap_order;
    logic                    i_in_valid;
    logic                    o_in_stall;
    logic                    i_req_type;
    logic signed [VAL_W-1:0] i_value;
    logic                    o_out_valid;
    logic                    i_out_stall;
    logic signed [VAL_W-1:0] o_top_value;
    logic [CW-1:0]           o_entry_count;
    logic                    o_is_empty;
    logic [STAT_W-1:0]       o_status;

    // Predicted heap contents and settings
    logic signed [VAL_W-1:0] model_heap [CAPACITY];
    int unsigned             model_count;
    logic                    model_order;
    t_heap_result            pending_results [$];

    int unsigned sent_items;
    int unsigned burst_left;
    bit          offering;
    bit          hold_request;
    bit          hold_active;
    int unsigned mismatches;
    int unsigned idle_cycles;

    binary_heap_priority_queue #(
        .CAPACITY(CAPACITY)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_heap_order(i_cfg_heap_order),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_req_type      (i_req_type),
        .i_value         (i_value),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_top_value     (o_top_value),
        .o_entry_count   (o_entry_count),
        .o_is_empty      (o_is_empty),
        .o_status        (o_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------- predictor

    function automatic logic outranks(input logic signed [VAL_W-1:0] a,
                                      input logic signed [VAL_W-1:0] b);
        return (model_order == ORDER_MAX) ? (a > b) : (a < b);
    endfunction

    function automatic void swap_entries(input int unsigned i, input int unsigned j);
        logic signed [VAL_W-1:0] t;
        t             = model_heap[i];
        model_heap[i] = model_heap[j];
        model_heap[j] = t;
    endfunction

    function automatic t_heap_result apply_heap_request(input logic req,
                                                        input logic signed [VAL_W-1:0] val);
        t_heap_result r;
        int unsigned  pos;
        int unsigned  up;
        int unsigned  kid;
        bit           done;
        r.status = ST_OK;
        if (req == REQ_INSERT) begin
            if (model_count >= CAPACITY) begin
                r.status = ST_FULL;
            end else begin
                // append, then climb while the new entry outranks its parent
                model_heap[model_count] = val;
                pos  = model_count;
                model_count++;
                done = 1'b0;
                while (!done && pos > 0) begin
                    up = (pos - 1) / 2;
                    if (outranks(model_heap[pos], model_heap[up])) begin
                        swap_entries(pos, up);
                        pos = up;
                    end else begin
                        done = 1'b1;
                    end
                end
            end
        end else if (model_count == 0) begin
            r.status = ST_EMPTY;
        end else begin
            // move last entry to the root and sink it; equal children pick the left one
            model_count--;
            model_heap[0] = model_heap[model_count];
            pos  = 0;
            done = 1'b0;
            while (!done) begin
                kid = 2 * pos + 1;
                if (kid >= model_count) begin
                    done = 1'b1;
                end else begin
                    if (kid + 1 < model_count && outranks(model_heap[kid + 1], model_heap[kid]))
                        kid++;
                    if (outranks(model_heap[kid], model_heap[pos])) begin
                        swap_entries(kid, pos);
                        pos = kid;
                    end else begin
                        done = 1'b1;
                    end
                end
            end
        end
        r.top_value   = (model_count == 0) ? '0 : model_heap[0];
        r.entry_count = CW'(model_count);
        r.is_empty    = (model_count == 0);
        return r;
    endfunction

    // ---------------------------------------------------------------- drivers

    function automatic logic signed [VAL_W-1:0] random_heap_value();
        case ($urandom_range(0, 7))
            0:       return 32'sh7FFF_FFFF - $urandom_range(0, 2);
            1:       return 32'sh8000_0000 + $urandom_range(0, 2);
            2, 3:    return $urandom_range(0, 8) - 4;   // narrow range, many ties
            default: return $urandom;
        endcase
    endfunction

    // Offer one request and hold it until accepted; bursts end with a gap.
    task automatic send_request(input logic req, input logic signed [VAL_W-1:0] val);
        if (!offering) begin
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(4, 20)) @(posedge i_clk);
            else
                repeat ($urandom_range(1, 3)) @(posedge i_clk);
            burst_left = $urandom_range(1, 30);
            offering   = 1'b1;
        end
        i_in_valid <= 1'b1;
        i_req_type <= req;
        i_value    <= val;
        do @(posedge i_clk); while (o_in_stall);
        pending_results.push_back(apply_heap_request(req, val));
        sent_items++;
        burst_left--;
        if (burst_left == 0) begin
            i_in_valid <= 1'b0;
            offering = 1'b0;
        end
    endtask

    task automatic release_input();
        if (offering) begin
            i_in_valid <= 1'b0;
            offering = 1'b0;
        end
    endtask

    task automatic wait_idle();
        release_input();
        while (pending_results.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic write_heap_order(input logic order);
        wait_idle();
        i_cfg_valid      <= 1'b1;
        i_cfg_heap_order <= order;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        model_order = order;
    endtask

    // Fill past capacity, optionally flip the order while full, then drain past empty.
    task automatic fill_then_empty(input bit flip_order);
        while (model_count < CAPACITY)
            send_request(REQ_INSERT, random_heap_value());
        repeat ($urandom_range(1, 3)) send_request(REQ_INSERT, random_heap_value());
        if (flip_order)
            write_heap_order(~model_order);
        while (model_count > 0)
            send_request(REQ_REMOVE, random_heap_value());
        repeat ($urandom_range(1, 3)) send_request(REQ_REMOVE, random_heap_value());
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_empty_heap();
        send_request(REQ_REMOVE, 32'sh1234_5678);
        send_request(REQ_INSERT, 32'sd42);
        send_request(REQ_REMOVE, '0);
    endtask

    task automatic test_min_order_extremes();
        send_request(REQ_INSERT, 32'sd0);
        send_request(REQ_INSERT, 32'sh7FFF_FFFF);
        send_request(REQ_INSERT, 32'sh8000_0000);
        send_request(REQ_INSERT, -32'sd1);
        send_request(REQ_INSERT, 32'sd1);
        send_request(REQ_INSERT, 32'sd5);
        send_request(REQ_INSERT, 32'sd5);
        send_request(REQ_INSERT, -32'sd1);
        repeat (4) send_request(REQ_REMOVE, 32'hFFFF_FFFF);
    endtask

    // Order is switched while entries are held; later sifts use the new order.
    task automatic test_max_order_and_switch();
        write_heap_order(ORDER_MAX);
        send_request(REQ_INSERT, 32'sh8000_0000);
        send_request(REQ_INSERT, 32'sh7FFF_FFFF);
        send_request(REQ_INSERT, 32'sd3);
        send_request(REQ_INSERT, 32'sd3);
        send_request(REQ_REMOVE, '0);
        write_heap_order(ORDER_MIN);
        send_request(REQ_REMOVE, '0);
        send_request(REQ_INSERT, 32'sd2);
        write_heap_order(ORDER_MAX);
        send_request(REQ_REMOVE, '0);
    endtask

    task automatic test_full_heap();
        fill_then_empty(1'b1);
    endtask

    // Receiver holds off while requests keep coming, so the input channel backs up.
    task automatic test_backpressure();
        release_input();
        hold_request = 1'b1;
        while (!hold_active) @(posedge i_clk);
        repeat (16) send_request($urandom_range(0, 2) ? REQ_INSERT : REQ_REMOVE,
                                 random_heap_value());
    endtask

    task automatic test_random_traffic();
        int unsigned insert_pct;
        int          mode;
        while (sent_items < TOTAL_ITEMS) begin
            write_heap_order($urandom_range(0, 1) ? ORDER_MAX : ORDER_MIN);
            mode = $urandom_range(0, 3);
            case (mode)
                0:       insert_pct = 50;
                1:       insert_pct = 75;
                default: insert_pct = 25;
            endcase
            if (mode == 3)
                fill_then_empty($urandom_range(0, 1) != 0);
            else
                repeat ($urandom_range(40, 120))
                    send_request(($urandom_range(1, 100) <= insert_pct) ? REQ_INSERT
                                                                        : REQ_REMOVE,
                                 random_heap_value());
        end
    endtask

    // ---------------------------------------------------------------- receiver

    initial begin : result_stall_gen
        int run_len;
        int style;
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                hold_active  = 1'b1;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_active = 1'b0;
            end else begin
                style   = $urandom_range(0, 2);
                run_len = $urandom_range(1, 40);
                repeat (run_len) begin
                    case (style)
                        0:       i_out_stall <= 1'b0;
                        1:       i_out_stall <= ($urandom_range(0, 1) != 0);
                        default: i_out_stall <= ($urandom_range(0, 3) != 0);
                    endcase
                    @(posedge i_clk);
                end
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_heap_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("unexpected result: top %0d count %0d empty %0b status %0d",
                             o_top_value, o_entry_count, o_is_empty, o_status);
            end else begin
                want = pending_results.pop_front();
                if (o_top_value !== want.top_value || o_entry_count !== want.entry_count ||
                    o_is_empty !== want.is_empty || o_status !== want.status) begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display({"result mismatch: expected top %0d count %0d empty %0b ",
                                  "status %0d, got top %0d count %0d empty %0b status %0d"},
                                 want.top_value, want.entry_count, want.is_empty,
                                 want.status, o_top_value, o_entry_count, o_is_empty,
                                 o_status);
                end
            end
        end
    end

    // Watchdog: too long with no transaction on any channel ends the run.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("binary_heap_priority_queue_tb failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ---------------------------------------------------------------- sequence

    initial begin
        model_count  = 0;
        model_order  = ORDER_MIN;
        sent_items   = 0;
        burst_left   = 0;
        offering     = 1'b0;
        hold_request = 1'b0;
        hold_active  = 1'b0;
        mismatches   = 0;
        idle_cycles  = 0;
        i_rst_n          <= 1'b0;
        i_cfg_valid      <= 1'b0;
        i_cfg_heap_order <= ORDER_MIN;
        i_in_valid       <= 1'b0;
        i_req_type       <= REQ_INSERT;
        i_value          <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_heap();
        test_min_order_extremes();
        test_max_order_and_switch();
        test_full_heap();
        test_backpressure();
        test_random_traffic();

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("binary_heap_priority_queue_tb passed");
        else
            $display("binary_heap_priority_queue_tb failed");
        $finish;
    end

endmodule
